>>> design/spr_pkg.sv
// Shared types and constants for the spindle RPM to PWM converter.
// No dependencies; every other design file imports this package.
package spr_pkg;

	localparam int PIECES_DEF = 4;

	localparam int RPM_W    = 17;
	localparam int GRAD_W   = 32;
	localparam int CNT16_W  = 16;
	localparam int SLOPE_W  = 24;
	localparam int OFS_W    = 22;
	localparam int PIU_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RPM_FLOOR  = 3'd0,
		REG_GRADIENT   = 3'd1,
		REG_DUTY_MIN   = 3'd2,
		REG_DUTY_MAX   = 3'd3,
		REG_PWM_PERIOD = 3'd4,
		REG_DUTY_OFF   = 3'd5,
		REG_INVERT     = 3'd6,
		REG_PIECES     = 3'd7
	} cfg_reg_t;

	// Request operation codes
	localparam logic OP_CONVERT = 1'b0;
	localparam logic OP_WRITE   = 1'b1;

	typedef struct packed {
		logic [RPM_W-1:0]   rpm_floor;
		logic [GRAD_W-1:0]  gradient;
		logic [CNT16_W-1:0] duty_min;
		logic [CNT16_W-1:0] duty_max;
		logic [CNT16_W-1:0] pwm_period;
		logic [CNT16_W-1:0] duty_off;
		logic               invert_output;
		logic [PIU_W-1:0]   pieces_in_use;
	} cfg_t;

	// Sequencer states, one-hot
	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_SEARCH = 11'b000_0000_0010,
		ST_PMUL   = 11'b000_0000_0100,
		ST_DIFF   = 11'b000_0000_1000,
		ST_MULLO  = 11'b000_0001_0000,
		ST_MULHI  = 11'b000_0010_0000,
		ST_ACCUM  = 11'b000_0100_0000,
		ST_LIN    = 11'b000_1000_0000,
		ST_LINADD = 11'b001_0000_0000,
		ST_CLAMP  = 11'b010_0000_0000,
		ST_DONE   = 11'b100_0000_0000
	} state_t;

endpackage

>>> design/spr_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on spr_pkg for operand widths.
module spr_mul import spr_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

endmodule

>>> design/spr_core.sv
// Sequencer, piece table and datapath of the RPM to PWM converter.
// Depends on spr_pkg and instantiates spr_mul.
module spr_core import spr_pkg::*; #(
	parameter int PIECES = PIECES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic [RPM_W-1:0]    rpm,
	input  logic                period_clamp,
	input  logic [1:0]          piece_index,
	input  logic [RPM_W-1:0]    piece_rpm,
	input  logic [SLOPE_W-1:0]  piece_start,
	input  logic signed [OFS_W-1:0] piece_end,
	output logic                res_valid,
	input  logic                res_take,
	output logic [CNT16_W-1:0]  res_value
);

	localparam int IDX_W = (PIECES > 1) ? $clog2(PIECES) : 1;
	localparam int CNT_W = $clog2(PIECES + 1);
	localparam int D_W   = 42;
	localparam int V_W   = 39;

	// Piece store, undefined until written
	logic [RPM_W-1:0]   thr_q   [PIECES];
	logic [SLOPE_W-1:0] slope_q [PIECES];
	logic [OFS_W-1:0]   ofs_q   [PIECES];

	state_t state_q;
	logic [RPM_W-1:0]   rpm_q;
	logic               pid_q;
	logic [IDX_W-1:0]   idx_q;
	logic [D_W-1:0]     d_q;
	logic [31:0]        acc_q;
	logic [V_W-1:0]     v_q;
	logic               off_q;
	logic               force_q;
	logic [CNT16_W-1:0] res_q;

	logic [CNT_W-1:0]   n_use;
	logic [RPM_W-1:0]   lin_diff;
	logic [D_W:0]       d_full;
	logic               mul_en;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic [CNT16_W-1:0] limit;
	logic [CNT16_W-1:0] ceil_val;
	logic [CNT16_W-1:0] clamp_val;
	logic [CNT16_W-1:0] base_val;
	logic [CNT16_W-1:0] final_val;
	logic               wr_ok;

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_value = res_q;

	// Saturate the piece count to the table depth
	assign n_use = (32'(cfg.pieces_in_use) > PIECES) ? CNT_W'(PIECES)
	                                                  : CNT_W'(cfg.pieces_in_use);
	assign wr_ok = (32'(piece_index) < PIECES);
	assign lin_diff = rpm_q - cfg.rpm_floor;

	// d = start * rpm - end * 2^16, sign in the top bit
	assign d_full = {2'b00, mul_p[40:0]}
	              - {{5{ofs_q[idx_q][OFS_W-1]}}, ofs_q[idx_q], 16'b0};

	always_comb begin
		mul_en = 1'b0;
		mul_a  = cfg.gradient;
		mul_b  = '0;
		unique case (state_q)
			ST_PMUL: begin
				mul_en = 1'b1;
				mul_a  = MUL_A_W'(rpm_q);
				mul_b  = slope_q[idx_q];
			end
			ST_MULLO: begin
				mul_en = 1'b1;
				mul_b  = MUL_B_W'(d_q[20:0]);
			end
			ST_MULHI: begin
				mul_en = 1'b1;
				mul_b  = MUL_B_W'(d_q[41:21]);
			end
			ST_LIN: begin
				mul_en = 1'b1;
				mul_b  = MUL_B_W'(lin_diff);
			end
			default: ;
		endcase
	end

	spr_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// Clamp, floor, zero-speed off value and invert
	always_comb begin
		limit     = pid_q ? cfg.pwm_period : cfg.duty_max;
		ceil_val  = pid_q ? (cfg.pwm_period - 16'd1) : cfg.duty_max;
		if (v_q >= V_W'(limit)) begin
			clamp_val = ceil_val;
		end else if (v_q < V_W'(cfg.duty_min)) begin
			clamp_val = cfg.duty_min;
		end else begin
			clamp_val = v_q[CNT16_W-1:0];
		end
		base_val = force_q ? cfg.duty_min : clamp_val;
		if (off_q) begin
			final_val = cfg.duty_off;
		end else if (cfg.invert_output) begin
			final_val = cfg.pwm_period - base_val - 16'd1;
		end else begin
			final_val = base_val;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid && (operation == OP_WRITE) && wr_ok) begin
			thr_q[IDX_W'(piece_index)]   <= piece_rpm;
			slope_q[IDX_W'(piece_index)] <= piece_start;
			ofs_q[IDX_W'(piece_index)]   <= piece_end;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rpm_q   <= rpm;
				pid_q   <= period_clamp;
				idx_q   <= IDX_W'(n_use - CNT_W'(1));
				off_q   <= (rpm == '0);
				force_q <= (rpm <= cfg.rpm_floor);
			end
			ST_SEARCH: begin
				if (!(idx_q == '0 || thr_q[idx_q] < rpm_q)) begin
					idx_q <= idx_q - IDX_W'(1);
				end
			end
			ST_DIFF: begin
				d_q <= d_full[D_W-1:0];
				if (d_full[D_W]) begin
					force_q <= 1'b1;
				end
			end
			ST_MULHI:  acc_q <= mul_p[52:21];
			ST_ACCUM:  v_q   <= V_W'((54'(mul_p[52:0]) + 54'(acc_q)) >> 15);
			ST_LINADD: v_q   <= V_W'(34'(mul_p[48:16]) + 34'(cfg.duty_min));
			ST_CLAMP:  res_q <= final_val;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && operation == OP_CONVERT) begin
						if (rpm <= cfg.rpm_floor) begin
							state_q <= ST_CLAMP;
						end else if (n_use == '0) begin
							state_q <= ST_LIN;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (idx_q == '0 || thr_q[idx_q] < rpm_q) begin
						state_q <= ST_PMUL;
					end
				end
				ST_PMUL:   state_q <= ST_DIFF;
				ST_DIFF:   state_q <= d_full[D_W] ? ST_CLAMP : ST_MULLO;
				ST_MULLO:  state_q <= ST_MULHI;
				ST_MULHI:  state_q <= ST_ACCUM;
				ST_ACCUM:  state_q <= ST_CLAMP;
				ST_LIN:    state_q <= ST_LINADD;
				ST_LINADD: state_q <= ST_CLAMP;
				ST_CLAMP:  state_q <= ST_DONE;
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> design/spindle_rpm_to_pwm_top.sv
// Top level of the spindle RPM to PWM converter: configuration registers,
// output register and the sequenced core. Depends on spr_pkg, spr_core.
//
// Usage:
//  Input channel (in_valid/in_ready): each request is either a convert
//  request (operation 0: rpm, period_clamp) or a piece write (operation 1:
//  piece_index, piece_rpm, piece_start, piece_end). A piece write gives no
//  result. A convert request gives one compare_val on the output channel
//  (out_valid/out_ready).
//  Configuration channel (cfg_valid/cfg_ready): always ready; cfg_index
//  picks the register, cfg_data carries the value. Write only while idle.
//  Timing: one request at a time, through one shared 32x24 multiplier
//  stepped by the sequencer. Zero RPM or RPM at or below the floor goes
//  straight to the clamp; the linear model multiplies, adds and clamps;
//  with pieces a threshold search leads to the piece product, difference,
//  low and high products, accumulate and clamp, or straight to the clamp
//  on a negative difference. The next request is taken after handover.
//  Stall: a result waits in the output register; the core finishes the
//  next request and holds its result until the register frees.
//  Reset: clears the control state and loads the register reset values;
//  piece entries stay undefined until written.
module spindle_rpm_to_pwm_top import spr_pkg::*; #(
	parameter int PIECES = PIECES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    operation,
	input  logic [RPM_W-1:0]        rpm,
	input  logic                    period_clamp,
	input  logic [1:0]              piece_index,
	input  logic [RPM_W-1:0]        piece_rpm,
	input  logic [SLOPE_W-1:0]      piece_start,
	input  logic signed [OFS_W-1:0] piece_end,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CNT16_W-1:0]      compare_val
);

	cfg_t               cfg_q;
	logic               out_valid_q;
	logic [CNT16_W-1:0] compare_val_q;
	logic               res_valid;
	logic               res_take;
	logic [CNT16_W-1:0] res_value;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rpm_floor     <= '0;
			cfg_q.gradient      <= '0;
			cfg_q.duty_min      <= '0;
			cfg_q.duty_max      <= 16'd65535;
			cfg_q.pwm_period    <= 16'd1000;
			cfg_q.duty_off      <= '0;
			cfg_q.invert_output <= 1'b0;
			cfg_q.pieces_in_use <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RPM_FLOOR:  cfg_q.rpm_floor     <= cfg_data[RPM_W-1:0];
				REG_GRADIENT:   cfg_q.gradient      <= cfg_data[GRAD_W-1:0];
				REG_DUTY_MIN:   cfg_q.duty_min      <= cfg_data[CNT16_W-1:0];
				REG_DUTY_MAX:   cfg_q.duty_max      <= cfg_data[CNT16_W-1:0];
				REG_PWM_PERIOD: cfg_q.pwm_period    <= cfg_data[CNT16_W-1:0];
				REG_DUTY_OFF:   cfg_q.duty_off      <= cfg_data[CNT16_W-1:0];
				REG_INVERT:     cfg_q.invert_output <= cfg_data[0];
				REG_PIECES:     cfg_q.pieces_in_use <= cfg_data[PIU_W-1:0];
				default: ;
			endcase
		end
	end

	// Hand a finished result over when the output register is empty or
	// being drained in the same cycle
	assign res_take = res_valid && (!out_valid_q || out_ready);

	spr_core #(
		.PIECES (PIECES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.rpm          (rpm),
		.period_clamp (period_clamp),
		.piece_index  (piece_index),
		.piece_rpm    (piece_rpm),
		.piece_start  (piece_start),
		.piece_end    (piece_end),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res_value    (res_value)
	);

	// Output register: hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			compare_val_q <= res_value;
		end
	end

	assign out_valid   = out_valid_q;
	assign compare_val = compare_val_q;

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for spindle_rpm_to_pwm_top: directed and random convert and piece
// write requests; each convert is predicted on acceptance and checked against compare_val.
// Depends on spr_pkg and the design files under design/.
module tb;
	import spr_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int PIECES       = PIECES_DEF;
	localparam int DRAIN_CYCLES = 24;        // settling margin after the last result
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 112;
	localparam int HOLD_AFTER   = 350;       // results seen before the long receiver hold
	localparam int HOLD_CYCLES  = 400;

	typedef struct {
		logic               op;
		logic [RPM_W-1:0]   speed;
		logic               pid;
		logic [1:0]         slot;
		logic [RPM_W-1:0]   thr;
		logic [SLOPE_W-1:0] slope;
		logic [OFS_W-1:0]   ofs;
	} spin_req_t;

	typedef struct {
		logic [RPM_W-1:0]          thr;
		logic [SLOPE_W-1:0]        slope;
		logic signed [OFS_W-1:0]   ofs;
	} piece_ent_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_RPM_FLOOR;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    operation = OP_CONVERT;
	logic [RPM_W-1:0]        rpm = '0;
	logic                    period_clamp = 1'b0;
	logic [1:0]              piece_index = '0;
	logic [RPM_W-1:0]        piece_rpm = '0;
	logic [SLOPE_W-1:0]      piece_start = '0;
	logic signed [OFS_W-1:0] piece_end = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [CNT16_W-1:0]      compare_val;

	// Predictor state: register copy and piece table, both updated on acceptance
	cfg_t       cfg_m;
	piece_ent_t piece_tbl [PIECES];

	spin_req_t          spin_req_q[$];     // requests waiting to be offered
	logic [CNT16_W-1:0] pwm_expect_q[$];   // predicted compare values, oldest first
	spin_req_t          nxt;
	logic [CNT16_W-1:0] pwm_want;

	bit steady = 1'b0;     // set for the stretch with no idling on either side
	int errors = 0;
	int pwm_seen = 0;
	int hold_left = 0;
	bit hold_taken = 1'b0;
	int cycles = 0;

	spindle_rpm_to_pwm_top #(.PIECES(PIECES)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.rpm          (rpm),
		.period_clamp (period_clamp),
		.piece_index  (piece_index),
		.piece_rpm    (piece_rpm),
		.piece_start  (piece_start),
		.piece_end    (piece_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.compare_val  (compare_val)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Expected compare value for one convert request under the current registers.
	function automatic logic [CNT16_W-1:0] predict_pwm(input logic [RPM_W-1:0] speed,
			input logic pid);
		int unsigned        n;
		int                 sel;
		longint             diff;
		logic [127:0]       wide;
		logic [63:0]        level;
		logic [63:0]        lim;
		logic [CNT16_W-1:0] duty;
		bit                 neg;
		neg = 1'b0;
		level = '0;
		if (speed == '0)
			return cfg_m.duty_off;
		duty = cfg_m.duty_min;
		if (speed > cfg_m.rpm_floor) begin
			n = (cfg_m.pieces_in_use > PIECES) ? PIECES : cfg_m.pieces_in_use;
			if (n != 0) begin
				// highest piece whose threshold lies strictly below the speed, else piece 0
				sel = n - 1;
				while (sel > 0 && speed <= piece_tbl[sel].thr)
					sel--;
				diff = longint'(piece_tbl[sel].slope) * longint'(speed)
					- longint'(piece_tbl[sel].ofs) * 65536;
				if (diff < 0) begin
					neg = 1'b1;
				end else begin
					wide = 128'(diff) * 128'(cfg_m.gradient);
					level = 64'(wide >> 36);
				end
			end else begin
				level = (((64'(speed) - 64'(cfg_m.rpm_floor)) * 64'(cfg_m.gradient)) >> 16)
					+ 64'(cfg_m.duty_min);
			end
			if (!neg) begin
				lim = pid ? 64'(cfg_m.pwm_period) : 64'(cfg_m.duty_max);
				if (level >= lim)
					duty = pid ? cfg_m.pwm_period - 16'd1 : cfg_m.duty_max;
				else if (level < 64'(cfg_m.duty_min))
					duty = cfg_m.duty_min;
				else
					duty = level[CNT16_W-1:0];
			end
		end
		if (cfg_m.invert_output)
			duty = cfg_m.pwm_period - duty - 16'd1;
		return duty;
	endfunction

	// Queue a convert request; the piece fields carry noise the block must ignore.
	function automatic void push_convert(input int unsigned speed, input bit pid);
		spin_req_t r;
		r.op    = OP_CONVERT;
		r.speed = speed[RPM_W-1:0];
		r.pid   = pid;
		r.slot  = 2'($urandom_range(0, 3));
		r.thr   = RPM_W'($urandom_range(0, 131071));
		r.slope = SLOPE_W'($urandom());
		r.ofs   = OFS_W'($urandom());
		spin_req_q.push_back(r);
	endfunction

	function automatic void push_piece(input int unsigned slot, input int unsigned thr,
			input int unsigned slope, input int ofs);
		spin_req_t r;
		r.op    = OP_WRITE;
		r.speed = RPM_W'($urandom_range(0, 131071));
		r.pid   = 1'($urandom_range(0, 1));
		r.slot  = slot[1:0];
		r.thr   = thr[RPM_W-1:0];
		r.slope = slope[SLOPE_W-1:0];
		r.ofs   = ofs[OFS_W-1:0];
		spin_req_q.push_back(r);
	endfunction

	// Piece that roughly continues the linear ramp from the floor, slope near unity.
	function automatic void plausible_piece(input int unsigned slot, input int unsigned fl,
			input int unsigned hi);
		int unsigned thr;
		int unsigned slope;
		int          e;
		thr   = fl + slot * (hi - fl) / 4;
		slope = $urandom_range(1 << 19, 1 << 21);
		e     = int'((longint'(fl) * 16 * slope) >>> 20) + int'($urandom_range(0, 4000)) - 2000;
		push_piece(slot, thr, slope, e);
	endfunction

	// Write one register over the configuration channel and mirror it in the predictor.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RPM_FLOOR:  cfg_m.rpm_floor     = val[RPM_W-1:0];
			REG_GRADIENT:   cfg_m.gradient      = val[GRAD_W-1:0];
			REG_DUTY_MIN:   cfg_m.duty_min      = val[CNT16_W-1:0];
			REG_DUTY_MAX:   cfg_m.duty_max      = val[CNT16_W-1:0];
			REG_PWM_PERIOD: cfg_m.pwm_period    = val[CNT16_W-1:0];
			REG_DUTY_OFF:   cfg_m.duty_off      = val[CNT16_W-1:0];
			REG_INVERT:     cfg_m.invert_output = val[0];
			REG_PIECES:     cfg_m.pieces_in_use = val[PIU_W-1:0];
			default: ;
		endcase
	endtask

	// Wait for every request to be taken and every result to arrive, then let a piece
	// write still in flight settle. Poll on the falling edge, clear of the drivers.
	task automatic wait_drained();
		do @(negedge clk);
		while (spin_req_q.size() != 0 || in_valid || pwm_expect_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_all(input int unsigned fl, input logic [31:0] g, input int unsigned dmin,
			input int unsigned dmax, input int unsigned per, input int unsigned off,
			input int unsigned inv, input int unsigned piu);
		write_reg(REG_RPM_FLOOR, fl);
		write_reg(REG_GRADIENT, g);
		write_reg(REG_DUTY_MIN, dmin);
		write_reg(REG_DUTY_MAX, dmax);
		write_reg(REG_PWM_PERIOD, per);
		write_reg(REG_DUTY_OFF, off);
		write_reg(REG_INVERT, inv);
		write_reg(REG_PIECES, piu);
	endtask

	// One random phase: fresh registers, a well-formed piece table, then a mix of
	// conversions aimed at the floor, the piece thresholds and the ramp, with some
	// plausible and some arbitrary piece rewrites.
	task automatic run_random_phase(input int ph);
		int unsigned fl, hi, per, dmin, dmax, off, inv, piu, spd, pick, k;
		logic [31:0] g;
		wait_drained();
		if (ph == 6) begin
			// top of every range
			fl = 0; hi = 131071; g = 32'hFFFF_FFFF; dmin = 0; dmax = 65535;
			per = 65535; off = 65535; inv = 1; piu = 4;
		end else if (ph == 8) begin
			// floor at the top, empty duty window, zero period
			fl = 131071; hi = 131071; g = '0; dmin = 65535; dmax = 0;
			per = 0; off = 0; inv = 0; piu = 7;
		end else begin
			fl   = $urandom_range(0, 4000);
			hi   = fl + $urandom_range(500, 100000);
			if (hi > 131071)
				hi = 131071;
			per  = $urandom_range(50, 65535);
			dmin = $urandom_range(0, per / 8);
			dmax = $urandom_range(per / 2, per);
			if ($urandom_range(0, 3) == 0)
				g = $urandom();
			else
				g = 32'((longint'(per - dmin) << 16) / longint'(hi - fl));
			off  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 0;
			inv  = $urandom_range(0, 1);
			piu  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
		end
		write_all(fl, g, dmin, dmax, per, off, inv, piu);
		@(negedge clk);
		steady = (ph == 3 || ph == 4);
		for (int s = 0; s < PIECES; s++)
			plausible_piece(s, fl, hi);
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				plausible_piece($urandom_range(0, 3), fl, hi);
			end else if (pick < 10) begin
				push_piece($urandom_range(0, 3), $urandom_range(0, 131071),
					$urandom_range(0, 24'hFF_FFFF), int'($urandom()));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					spd = 0;
				end else if (pick < 15) begin
					spd = $urandom_range(0, fl);
				end else if (pick < 30) begin
					// straddle a piece threshold
					k   = $urandom_range(1, 3);
					spd = fl + k * (hi - fl) / 4 + $urandom_range(0, 4) - 2;
					if (spd > 131071)
						spd = 131071;
				end else if (pick < 75) begin
					spd = $urandom_range(fl, hi);
				end else begin
					spd = $urandom_range(0, 131071);
				end
				push_convert(spd, $urandom_range(0, 1));
			end
		end
	endtask

	// Request driver: predict each accepted request, then offer the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (operation == OP_WRITE) begin
					if (piece_index < PIECES)
						piece_tbl[piece_index] = '{piece_rpm, piece_start, piece_end};
				end else begin
					pwm_expect_q.push_back(predict_pwm(rpm, period_clamp));
				end
			end
			if (!in_valid || in_ready) begin
				if (spin_req_q.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
					nxt = spin_req_q.pop_front();
					in_valid     <= 1'b1;
					operation    <= nxt.op;
					rpm          <= nxt.speed;
					period_clamp <= nxt.pid;
					piece_index  <= nxt.slot;
					piece_rpm    <= nxt.thr;
					piece_start  <= nxt.slope;
					piece_end    <= nxt.ofs;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check against the oldest prediction, drive out_ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pwm_expect_q.size() == 0) begin
					$display("%0t: compare_val expected none actual %0d", $time, compare_val);
					errors++;
				end else begin
					pwm_want = pwm_expect_q.pop_front();
					if (compare_val !== pwm_want) begin
						$display("%0t: compare_val expected %0d actual %0d",
							$time, pwm_want, compare_val);
						errors++;
					end
				end
				pwm_seen++;
			end
			// hold off once for a long stretch so the block fills and stalls its input
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_taken && pwm_seen >= HOLD_AFTER) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || $urandom_range(0, 99) >= 27;
			end
		end
	end

	// Drop out if the run hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pwm_expect_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		cfg_m = '{rpm_floor: '0, gradient: '0, duty_min: '0, duty_max: 16'hFFFF,
			pwm_period: 16'd1000, duty_off: '0, invert_output: 1'b0, pieces_in_use: '0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset registers: zero speed, speed just above the floor, full speed with the period clamp.
		// Load every piece entry before any setting reads the table.
		push_convert(0, 0);
		push_convert(1, 0);
		push_convert(131071, 1);
		push_piece(0, 0, 1 << 20, 16000);
		push_piece(1, 2000, 1 << 20, 48000);      // negative term just above its threshold
		push_piece(2, 6000, 3 << 19, 16000);
		push_piece(3, 20000, 1 << 19, -16000);    // negative offset

		// Plain linear model
		wait_drained();
		write_all(1000, 32'h0000_4000, 40, 900, 1000, 5, 0, 0);
		@(negedge clk);
		push_convert(0, 0);
		push_convert(1000, 0);
		push_convert(1001, 1);
		push_convert(4000, 0);
		push_convert(131071, 0);
		push_convert(131071, 1);

		// Piecewise fit, inverted output
		wait_drained();
		write_reg(REG_PIECES, 4);
		write_reg(REG_INVERT, 1);
		@(negedge clk);
		push_convert(1500, 0);
		push_convert(2001, 0);
		push_convert(10000, 0);
		push_convert(50000, 1);
		push_convert(1000, 1);
		push_convert(0, 1);

		// Extremes: zero floor, full gradient, empty duty window, zero period, pieces
		// beyond the table size, extreme piece fields
		wait_drained();
		write_all(0, 32'hFFFF_FFFF, 65535, 0, 0, 65535, 1, 7);
		@(negedge clk);
		push_piece(3, 131070, 24'hFF_FFFF, -2097152);
		push_piece(2, 0, 0, 2097151);
		push_convert(131071, 0);
		push_convert(131071, 1);
		push_convert(1, 0);

		for (int ph = 0; ph < RAND_PHASES; ph++)
			run_random_phase(ph);

		wait_drained();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> spindle_rpm_to_pwm_top.f
design/spr_pkg.sv
design/spr_mul.sv
design/spr_core.sv
design/spindle_rpm_to_pwm_top.sv
test/tb.sv
